// ----- rtl/button_multi_click_detector_top_defines.svh -----
// Assertion macros for the button multi-click detector.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef BUTTON_MULTI_CLICK_DETECTOR_TOP_DEFINES_SVH
`define BUTTON_MULTI_CLICK_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMCD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bmcd_pkg.sv -----
// Shared constants, types and a helper function of the button multi-click detector.
// No dependencies; imported by bmcd_dp, bmcd_ctrl and the top level.
package bmcd_pkg;

   localparam int RING_DEPTH = 32;
   localparam int TIME_WIDTH = 32;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int ENTRY_W    = TIME_WIDTH + 1;
   localparam int REQ_DATA_W = ((TIME_WIDTH + 1 + 7) / 8) * 8;
   localparam int COUNT_W    = 6;
   localparam int QSIZE_W    = 6;
   localparam int EXT_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int RSP_DATA_W = 8;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CMP_W      = (TIME_WIDTH > CSR_DATA_W) ? TIME_WIDTH : CSR_DATA_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLICKS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_GAP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TIME = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_EN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK_EN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_QSIZE     = 3'd4;

   typedef struct packed {
      logic latch_in;
      logic ring_write;
      logic load_ack;
      logic drain_init;
      logic take;
      logic proc;
      logic load_cnt;
      logic load_long;
      logic rep_last;
   } dp_cmd_type;

   typedef struct packed {
      logic is_update;
      logic drain_ok;
      logic ring_empty;
      logic out_free;
      logic rep_cnt;
      logic rep_long;
   } dp_stat_type;

   // Ring pointer increment, wrapping at the programmed queue size.
   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx,
                                                     input logic [CNT_W-1:0] qsize);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= qsize) ? '0 : nxt[RING_AW-1:0];
   endfunction

endpackage

// ----- rtl/bmcd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the event ring of the detector.
module bmcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bmcd_dp.sv -----
// Datapath of the detector: request latch, configuration registers, event ring,
// drain scan registers and the result register. Uses bmcd_pkg and bmcd_ram.
module bmcd_dp import bmcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_cmd,
   input  logic [TIME_WIDTH-1:0] req_ts,
   input  logic                  req_pressed,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic                  rsp_accepted,
   output logic                  rsp_level,
   output logic [COUNT_W-1:0]    rsp_count,
   output logic                  rsp_last
);

   localparam logic [1:0] PH_SKIP     = 2'd0;
   localparam logic [1:0] PH_PRESS    = 2'd1;
   localparam logic [1:0] PH_RELEASED = 2'd2;

   logic                  cmd_ff, cmd_in;
   logic [TIME_WIDTH-1:0] ts_ff, ts_in;
   logic                  pressed_ff, pressed_in;

   logic [CSR_DATA_W-1:0] gap_ff, gap_in;
   logic [CSR_DATA_W-1:0] long_time_ff, long_time_in;
   logic                  long_en_ff, long_en_in;
   logic                  click_en_ff, click_en_in;
   logic [CNT_W-1:0]      qsize_ff, qsize_in;

   logic [RING_AW-1:0]    head_ff, head_in;
   logic [RING_AW-1:0]    tail_ff, tail_in;
   logic                  full_ff, full_in;
   logic [TIME_WIDTH-1:0] lct_ff, lct_in;
   logic                  level_ff, level_in;

   logic [1:0]            phase_ff, phase_in;
   logic [CNT_W-1:0]      clicks_ff, clicks_in;
   logic                  longp_ff, longp_in;
   logic [TIME_WIDTH-1:0] press_ts_ff, press_ts_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic                  rsp_lvl_ff, rsp_lvl_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  ram_we;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic [ENTRY_W-1:0]    ram_rdata;

   logic [RING_AW-1:0]    head_next;
   logic [RING_AW-1:0]    tail_next;
   logic                  ring_empty;
   logic [TIME_WIDTH-1:0] since_change;
   logic                  gap_hit;
   logic                  ent_lvl;
   logic [TIME_WIDTH-1:0] ent_ts;
   logic [TIME_WIDTH-1:0] press_len;
   logic                  long_hit;
   logic [CNT_W-1:0]      net_clicks;
   logic [COUNT_W-1:0]    sat_clicks;
   logic [EXT_W-1:0]      qs_raw;
   logic [CNT_W-1:0]      qs_clamped;

   bmcd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_ff),
      .wr_data (ram_wdata),
      .rd_en   (cmd.take),
      .rd_addr (tail_ff),
      .rd_data (ram_rdata)
   );

   assign head_next    = ring_next(head_ff, qsize_ff);
   assign tail_next    = ring_next(tail_ff, qsize_ff);
   assign ring_empty   = !full_ff && (head_ff == tail_ff);
   assign since_change = ts_ff - lct_ff;
   assign gap_hit      = (gap_ff == '0) || (CMP_W'(since_change) >= CMP_W'(gap_ff));

   assign ent_lvl   = ram_rdata[TIME_WIDTH];
   assign ent_ts    = ram_rdata[TIME_WIDTH-1:0];
   assign press_len = ent_ts - press_ts_ff;
   assign long_hit  = long_en_ff && (long_time_ff != '0) &&
                      (CMP_W'(press_len) >= CMP_W'(long_time_ff));

   // Clicks reported exclude the long click, saturated to the field width.
   assign net_clicks = clicks_ff - CNT_W'(longp_ff);
   assign sat_clicks = (EXT_W'(net_clicks) > EXT_W'(COUNT_MAX)) ? COUNT_MAX
                                                                 : COUNT_W'(net_clicks);

   assign qs_raw     = EXT_W'(csr_data[QSIZE_W-1:0]);
   assign qs_clamped = (qs_raw < EXT_W'(2))          ? CNT_W'(2) :
                       (qs_raw > EXT_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) :
                                                       CNT_W'(qs_raw);

   always_comb begin
      cmd_in       = cmd_ff;
      ts_in        = ts_ff;
      pressed_in   = pressed_ff;
      gap_in       = gap_ff;
      long_time_in = long_time_ff;
      long_en_in   = long_en_ff;
      click_en_in  = click_en_ff;
      qsize_in     = qsize_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      full_in      = full_ff;
      lct_in       = lct_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      clicks_in    = clicks_ff;
      longp_in     = longp_ff;
      press_ts_in  = press_ts_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_wdata    = {pressed_ff, ts_ff};

      if (cmd.latch_in) begin
         cmd_in     = req_cmd;
         ts_in      = req_ts;
         pressed_in = req_pressed;
      end

      // A level change always updates the level; it is stored only if there is room.
      if (cmd.ring_write) begin
         level_in = pressed_ff;
         if (!full_ff) begin
            ram_we  = 1'b1;
            lct_in  = ts_ff;
            head_in = head_next;
            full_in = (head_next == tail_ff);
         end
      end

      if (cmd.take) begin
         tail_in = tail_next;
         full_in = 1'b0;
      end

      if (cmd.drain_init) begin
         phase_in  = PH_SKIP;
         clicks_in = '0;
         longp_in  = 1'b0;
      end

      // One ring entry per cycle. Only the first press of a run sets the press time;
      // a release ends the press and decides whether it was a long one.
      if (cmd.proc) begin
         case (phase_ff)
            PH_SKIP, PH_RELEASED: begin
               if (ent_lvl) begin
                  clicks_in   = clicks_ff + CNT_W'(1);
                  press_ts_in = ent_ts;
                  phase_in    = PH_PRESS;
               end
            end
            PH_PRESS: begin
               if (!ent_lvl) begin
                  longp_in = long_hit;
                  phase_in = PH_RELEASED;
               end
            end
            default: begin
               phase_in = PH_SKIP;
            end
         endcase
      end

      if (csr_we) begin
         case (csr_index)
            REG_GAP:       gap_in       = csr_data;
            REG_LONG_TIME: long_time_in = csr_data;
            REG_LONG_EN:   long_en_in   = csr_data[0];
            REG_CLICK_EN:  click_en_in  = csr_data[0];
            REG_QSIZE: begin
               qsize_in = qs_clamped;
               head_in  = '0;
               tail_in  = '0;
               full_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.load_ack) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_ACK;
         rsp_acc_in   = !full_ff;
         rsp_lvl_in   = pressed_ff;
         rsp_cnt_in   = '0;
         rsp_last_in  = 1'b1;
      end else if (cmd.load_cnt) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_CLICKS;
         rsp_acc_in   = 1'b0;
         rsp_lvl_in   = 1'b0;
         rsp_cnt_in   = sat_clicks;
         rsp_last_in  = cmd.rep_last;
      end else if (cmd.load_long) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_LONG;
         rsp_acc_in   = 1'b0;
         rsp_lvl_in   = 1'b0;
         rsp_cnt_in   = '0;
         rsp_last_in  = cmd.rep_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= '0;
         long_time_ff <= '0;
         long_en_ff   <= 1'b0;
         click_en_ff  <= 1'b1;
         qsize_ff     <= CNT_W'(RING_DEPTH);
         head_ff      <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b0;
         lct_ff       <= '0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gap_ff       <= gap_in;
         long_time_ff <= long_time_in;
         long_en_ff   <= long_en_in;
         click_en_ff  <= click_en_in;
         qsize_ff     <= qsize_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         lct_ff       <= lct_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ts_ff       <= ts_in;
      pressed_ff  <= pressed_in;
      phase_ff    <= phase_in;
      clicks_ff   <= clicks_in;
      longp_ff    <= longp_in;
      press_ts_ff <= press_ts_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign stat.is_update  = cmd_ff;
   assign stat.drain_ok   = !level_ff && (lct_ff != '0) && !ring_empty && gap_hit;
   assign stat.ring_empty = ring_empty;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.rep_cnt    = (phase_ff == PH_RELEASED) && click_en_ff &&
                            (clicks_ff > CNT_W'(longp_ff));
   assign stat.rep_long   = (phase_ff == PH_RELEASED) && longp_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_level    = rsp_lvl_ff;
   assign rsp_count    = rsp_cnt_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ----- rtl/bmcd_ctrl.sv -----
// Controller state machine of the detector: sequences request intake, ring writes,
// the drain scan and the reports. Uses bmcd_pkg; drives bmcd_dp by commands.
module bmcd_ctrl import bmcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECIDE   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_FINISH   = 3'd3;
   localparam logic [2:0] S_REP_CNT  = 3'd4;
   localparam logic [2:0] S_REP_LONG = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_in = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.is_update) begin
               if (stat.out_free) begin
                  cmd.ring_write = 1'b1;
                  cmd.load_ack   = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (stat.drain_ok) begin
               cmd.drain_init = 1'b1;
               cmd.take       = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            // The entry read last cycle is evaluated while the next one is fetched.
            cmd.proc = 1'b1;
            if (!stat.ring_empty) begin
               cmd.take = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rep_cnt) begin
               state_in = S_REP_CNT;
            end else if (stat.rep_long) begin
               state_in = S_REP_LONG;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_REP_CNT: begin
            if (stat.out_free) begin
               cmd.load_cnt = 1'b1;
               cmd.rep_last = !stat.rep_long;
               state_in     = stat.rep_long ? S_REP_LONG : S_IDLE;
            end
         end
         S_REP_LONG: begin
            if (stat.out_free) begin
               cmd.load_long = 1'b1;
               cmd.rep_last  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ----- rtl/button_multi_click_detector_top.sv -----
// Top level of the button multi-click detector; uses bmcd_pkg, bmcd_ctrl, bmcd_dp.
// A level change is acknowledged from S_DECIDE once the response output is free.
// An update that drains the ring scans its entries in S_SCAN, then reports through
// S_FINISH, S_REP_CNT and S_REP_LONG. One request is taken at a time; the ring
// scan reads one entry per cycle. Reset is synchronous: pointers, level and
// configuration registers return to defaults; the scan registers are not reset.
`include "button_multi_click_detector_top_defines.svh"

module button_multi_click_detector_top import bmcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // timestamp, pressed, zero fill
   input  logic                  req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // accepted, level, click_count
   output logic [KIND_W-1:0]     rsp_tuser,   // kind
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type         dp_cmd;
   dp_stat_type        dp_stat;
   logic               rsp_accepted;
   logic               rsp_level;
   logic [COUNT_W-1:0] rsp_count;
   logic               req_fire;
   logic               ack_out;
   logic               ack_ok;

   assign csr_ready = 1'b1;

   bmcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bmcd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_cmd      (req_tuser),
      .req_ts       (req_tdata[TIME_WIDTH-1:0]),
      .req_pressed  (req_tdata[TIME_WIDTH]),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (dp_cmd),
      .stat         (dp_stat),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_accepted (rsp_accepted),
      .rsp_level    (rsp_level),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {rsp_count, rsp_level, rsp_accepted};

   assign req_fire = req_tvalid && req_tready;
   assign ack_out  = rsp_tvalid && (rsp_tuser == KIND_ACK);
   assign ack_ok   = rsp_tlast && (rsp_tdata[RSP_DATA_W-1:2] == '0);

   `BMCD_ASSERT_NEXT(a_one_request_at_a_time, req_fire, !req_tready, "request accepted while busy")
   `BMCD_ASSERT_IMPL(a_ack_is_single, ack_out, ack_ok, "malformed acknowledgement")
   `BMCD_ASSERT_IMPL(a_no_take_when_empty, dp_cmd.take, !dp_stat.ring_empty, "ring read while empty")

endmodule
